// ----- design/interval_set_domain_engine_unit_assert.svh -----
// Assertion macros for the interval set domain engine.
// Used by the top level; needs a clk and rst signal in scope.
`ifndef INTERVAL_SET_DOMAIN_ENGINE_UNIT_ASSERT_SVH
`define INTERVAL_SET_DOMAIN_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define ISDE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("isde check failed");

// next-cycle implication
`define ISDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isde check failed");

`endif

// ----- design/isde_pkg.sv -----
// Shared types and constants for the interval set domain engine.
// No dependencies.
`timescale 1ns / 1ps
package isde_pkg;
  localparam int MAX_PAIRS = 16;
  localparam int DEPTH = MAX_PAIRS + 1;
  localparam int QW = $clog2(DEPTH + 1);

  localparam logic [2:0] CMD_ADD_RANGE = 3'd0;
  localparam logic [2:0] CMD_ADD_VALUE = 3'd1;
  localparam logic [2:0] CMD_SHRINK = 3'd2;
  localparam logic [2:0] CMD_QUERY = 3'd3;
  localparam logic [2:0] CMD_RELOAD = 3'd4;

  localparam logic [1:0] REG_INITIAL_LOW = 2'd0;
  localparam logic [1:0] REG_INITIAL_HIGH = 2'd1;
  localparam logic [1:0] REG_PAIR_LIMIT = 2'd2;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;
endpackage

// ----- design/isde_cell.sv -----
// One cell of the interval queue: holds one interval.
// Depends on isde_pkg.
`timescale 1ns / 1ps
module isde_cell (
  input  logic              clk,
  input  logic              rst,
  input  isde_pkg::cell_ctl_t ctl,
  input  isde_pkg::entry_t  nbr,
  input  isde_pkg::entry_t  wdata,
  output isde_pkg::entry_t  ent
);
  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (ctl.load) begin
      ent <= wdata;
    end else if (ctl.shift) begin
      ent <= nbr;
    end
  end
endmodule

// ----- design/interval_set_domain_engine_unit.sv -----
// Interval set domain engine: a queue of interval cells and the pass control.
// Depends on isde_pkg, isde_cell and interval_set_domain_engine_unit_assert.svh.
//
// Usage: a request (cmd, low_value, high_value) is taken on in_valid/in_ready.
// The stored intervals live sorted in a row of cells that works as a queue.
// Each request makes one pass: every cycle but an insertion step, the head
// interval leaves cell 0, the row shifts toward it, and the rewritten interval
// (if any) joins at the tail. An insertion joins the tail without consuming.
// One request is in work at a time, and the next is taken in the cycle after
// the result posts. One result per request on out_valid/out_ready; the result
// sits in an output register, so a new request is taken while it waits. If the
// receiver stalls, the next pass finishes and holds until the register frees.
// Configuration (cfg_write, cfg_index, cfg_data) takes effect at once: the
// initial bounds clamp add-value requests and set the reload interval, and the
// pair limit caps the interval count after an add. Reset leaves one interval
// [0, 0], pair limit 16, no result pending.
`timescale 1ns / 1ps
`include "interval_set_domain_engine_unit_assert.svh"
module interval_set_domain_engine_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] low_value,
  input  logic signed [31:0] high_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_member,
  output logic               is_empty,
  output logic               is_single,
  output logic               overflow,
  output logic signed [31:0] domain_low,
  output logic signed [31:0] domain_high,
  output logic [32:0]        element_count,
  output logic [4:0]         interval_count
);
  localparam int D = isde_pkg::DEPTH;
  localparam int QW = isde_pkg::QW;

  typedef enum logic [1:0] {M_KEEP, M_UNION, M_CLIP, M_DROP} mode_t;
  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  logic signed [31:0] initial_low, initial_high;
  logic [4:0] pair_limit;

  isde_pkg::entry_t cells [D];
  isde_pkg::entry_t nbrs [D];
  isde_pkg::cell_ctl_t ctls [D];

  state_t state;
  mode_t mode;
  logic [QW-1:0] q, q_next, r, wr_pos, lim;
  logic signed [31:0] ulo, uhi, ml, mh, mv;
  logic placed, member, chk_member, unite, report;
  logic acc_any;
  logic signed [31:0] acc_first, acc_last;
  logic [32:0] acc_total;

  isde_pkg::entry_t head, edata;
  logic emit, consume, finish, hit, ovf;
  logic signed [31:0] ml_next, mh_next, vclamp;
  logic placed_next;

  assign head = cells[0];
  assign wr_pos = q - QW'(consume);
  assign q_next = q - QW'(consume) + QW'(emit);
  assign hit = (r != '0) && (mv >= head.lo) && (mv <= head.hi);

  always_comb begin
    if (pair_limit == 5'd0) begin
      lim = QW'(1);
    end else if (32'(pair_limit) > isde_pkg::MAX_PAIRS) begin
      lim = QW'(isde_pkg::MAX_PAIRS);
    end else begin
      lim = QW'(pair_limit);
    end
  end

  always_comb begin
    vclamp = low_value;
    if (vclamp < initial_low) vclamp = initial_low;
    if (vclamp > initial_high) vclamp = initial_high;
  end

  always_comb begin
    emit = 1'b0;
    consume = 1'b0;
    finish = 1'b0;
    edata = head;
    ml_next = ml;
    mh_next = mh;
    placed_next = placed;
    if (state == ST_RUN) begin
      if (r != '0) begin
        case (mode)
          M_KEEP: begin
            emit = 1'b1;
            consume = 1'b1;
          end
          M_CLIP: begin
            consume = 1'b1;
            emit = !(head.hi < ulo || head.lo > uhi);
            edata.lo = (head.lo < ulo) ? ulo : head.lo;
            edata.hi = (head.hi > uhi) ? uhi : head.hi;
          end
          M_DROP: begin
            consume = 1'b1;
          end
          M_UNION: begin
            if (placed || head.hi < ulo) begin
              emit = 1'b1;
              consume = 1'b1;
            end else if (head.lo > uhi) begin
              emit = 1'b1;
              edata.lo = ml;
              edata.hi = mh;
              placed_next = 1'b1;
            end else begin
              consume = 1'b1;
              if (head.lo < ml) ml_next = head.lo;
              if (head.hi > mh) mh_next = head.hi;
            end
          end
          default: begin
            emit = 1'b1;
            consume = 1'b1;
          end
        endcase
      end else if (!placed) begin
        emit = 1'b1;
        edata.lo = ml;
        edata.hi = mh;
        placed_next = 1'b1;
      end else begin
        finish = 1'b1;
      end
    end
  end

  assign ovf = unite && (q > lim) && !(chk_member && member);

  for (genvar i = 0; i < D; i++) begin : g_cell
    if (i < D - 1) begin : g_mid
      assign nbrs[i] = cells[i+1];
    end else begin : g_end
      assign nbrs[i] = cells[i];
    end
    assign ctls[i].shift = consume;
    assign ctls[i].load = emit && (wr_pos == QW'(i));
    isde_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctls[i]),
      .nbr  (nbrs[i]),
      .wdata(edata),
      .ent  (cells[i])
    );
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_low <= '0;
      initial_high <= '0;
      pair_limit <= 5'd16;
    end else if (cfg_write) begin
      case (cfg_index)
        isde_pkg::REG_INITIAL_LOW: initial_low <= cfg_data;
        isde_pkg::REG_INITIAL_HIGH: initial_high <= cfg_data;
        isde_pkg::REG_PAIR_LIMIT: pair_limit <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      q <= QW'(1);
      out_valid <= 1'b0;
      placed <= 1'b1;
      r <= '0;
    end else begin
      if (out_valid && out_ready && !finish) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
            r <= q;
            member <= 1'b0;
            acc_any <= 1'b0;
            acc_total <= '0;
            acc_first <= '0;
            acc_last <= '0;
            ulo <= low_value;
            uhi <= high_value;
            ml <= low_value;
            mh <= high_value;
            mv <= low_value;
            chk_member <= 1'b0;
            unite <= 1'b0;
            report <= 1'b0;
            placed <= 1'b1;
            mode <= M_KEEP;
            case (cmd)
              isde_pkg::CMD_ADD_RANGE: begin
                if (high_value >= low_value) begin
                  mode <= M_UNION;
                  placed <= 1'b0;
                  unite <= 1'b1;
                end
              end
              isde_pkg::CMD_ADD_VALUE: begin
                mode <= M_UNION;
                placed <= 1'b0;
                unite <= 1'b1;
                chk_member <= 1'b1;
                ulo <= vclamp;
                uhi <= vclamp;
                ml <= vclamp;
                mh <= vclamp;
                mv <= vclamp;
              end
              isde_pkg::CMD_SHRINK: begin
                mode <= (high_value >= low_value) ? M_CLIP : M_DROP;
              end
              isde_pkg::CMD_QUERY: begin
                report <= 1'b1;
              end
              isde_pkg::CMD_RELOAD: begin
                mode <= M_DROP;
                ml <= initial_low;
                mh <= initial_high;
                placed <= !(initial_high >= initial_low);
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          if (finish) begin
            if (!out_valid || out_ready) begin
              out_valid <= 1'b1;
              is_member <= report && member;
              overflow <= ovf;
              if (ovf || q == '0) begin
                q <= '0;
                is_empty <= 1'b1;
                is_single <= 1'b0;
                domain_low <= '0;
                domain_high <= '0;
                element_count <= '0;
                interval_count <= '0;
              end else begin
                is_empty <= 1'b0;
                is_single <= (acc_total == 33'd1);
                domain_low <= acc_first;
                domain_high <= acc_last;
                element_count <= acc_total;
                interval_count <= 5'(q);
              end
              state <= ST_IDLE;
            end
          end else begin
            q <= q_next;
            r <= r - QW'(consume);
            placed <= placed_next;
            ml <= ml_next;
            mh <= mh_next;
            if (hit) member <= 1'b1;
            if (emit) begin
              acc_any <= 1'b1;
              if (!acc_any) acc_first <= edata.lo;
              acc_last <= edata.hi;
              acc_total <= acc_total + ({edata.hi[31], edata.hi}
                           - {edata.lo[31], edata.lo} + 33'd1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ISDE_ASSERT_NOW(a_store_bound, in_ready, q <= QW'(isde_pkg::MAX_PAIRS))
  `ISDE_ASSERT_NOW(a_ovf_empty, out_valid && overflow, is_empty && interval_count == 5'd0)
  `ISDE_ASSERT_NOW(a_single_bounds, out_valid && is_single, domain_low == domain_high)
  `ISDE_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
endmodule
